// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the responder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define DNSR_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: property failed");

// Condition must never be seen outside reset.
`define DNSR_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");

`endif

// ----- hw/rtl/dnsr_pkg.sv -----
// Types, constants and helpers shared by the DNS responder modules.
`default_nettype none

package dnsr_pkg;

    localparam int MAX_PACKET_DEF = 512;
    localparam int MAX_DOMAIN     = 31;
    localparam int NAME_CHARS     = 31;
    localparam int NAME_POS_W     = 6;
    localparam int HDR_BYTES      = 12;
    localparam int ANSWER_BYTES   = 16;
    localparam int ANS_IDX_W      = $clog2(ANSWER_BYTES);
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 64;

    localparam logic [31:0] IPV4_RESET = 32'hAC0E_0A01;
    localparam logic [7:0]  DOT_CHAR   = 8'h2E;
    localparam logic [7:0]  QR_BIT     = 8'h80;

    // header byte positions that get rewritten
    localparam int POS_FLAGS_HI   = 2;
    localparam int POS_FLAGS_LO   = 3;
    localparam int POS_ANCOUNT_LO = 7;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CHARS_LO,
        CFG_CHARS_MID,
        CFG_CHARS_HI,
        CFG_CHARS_TOP,
        CFG_DOM_LEN,
        CFG_IPV4
    } dnsr_cfg_index_t;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_LABEL,
        PH_DONE
    } dnsr_phase_t;

    typedef struct packed {
        logic [NAME_CHARS-1:0][7:0] chars;
        logic [4:0]                 dom_len;
        logic [31:0]                ipv4;
    } dnsr_cfg_t;

    typedef struct packed {
        logic       fire;
        logic       last;
        logic       keep;
        logic [7:0] data;
    } dnsr_echo_t;

    // Fixed A-record answer: pointer, type A, class IN, TTL 60, RDLENGTH 4, address.
    function automatic logic [7:0] answer_byte(input logic [ANS_IDX_W-1:0] idx,
                                               input logic [31:0] ipv4);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'hC0;
            4'd1:    b = 8'h0C;
            4'd2:    b = 8'h00;
            4'd3:    b = 8'h01;
            4'd4:    b = 8'h00;
            4'd5:    b = 8'h01;
            4'd6:    b = 8'h00;
            4'd7:    b = 8'h00;
            4'd8:    b = 8'h00;
            4'd9:    b = 8'h3C;
            4'd10:   b = 8'h00;
            4'd11:   b = 8'h04;
            4'd12:   b = ipv4[31:24];
            4'd13:   b = ipv4[23:16];
            4'd14:   b = ipv4[15:8];
            default: b = ipv4[7:0];
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dnsr_cfg_regs.sv -----
// Configuration register file for the DNS responder.
`default_nettype none

module dnsr_cfg_regs
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [dnsr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [dnsr_pkg::CFG_DATA_W-1:0]    cfg_data,
    output dnsr_pkg::dnsr_cfg_t                     cfg
);

    logic [63:0] chars_lo_reg;
    logic [63:0] chars_mid_reg;
    logic [63:0] chars_hi_reg;
    logic [55:0] chars_top_reg;
    logic [4:0]  dom_len_reg;
    logic [31:0] ipv4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars_lo_reg  <= '0;
            chars_mid_reg <= '0;
            chars_hi_reg  <= '0;
            chars_top_reg <= '0;
            dom_len_reg   <= '0;
            ipv4_reg      <= dnsr_pkg::IPV4_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dnsr_pkg::CFG_CHARS_LO:  chars_lo_reg  <= cfg_data;
                dnsr_pkg::CFG_CHARS_MID: chars_mid_reg <= cfg_data;
                dnsr_pkg::CFG_CHARS_HI:  chars_hi_reg  <= cfg_data;
                dnsr_pkg::CFG_CHARS_TOP: chars_top_reg <= cfg_data[55:0];
                dnsr_pkg::CFG_DOM_LEN:   dom_len_reg   <= cfg_data[4:0];
                dnsr_pkg::CFG_IPV4:      ipv4_reg      <= cfg_data[31:0];
                default: ; // unused index, write dropped
            endcase
        end
    end

    assign cfg.chars   = {chars_top_reg, chars_hi_reg, chars_mid_reg, chars_lo_reg};
    assign cfg.dom_len = dom_len_reg;
    assign cfg.ipv4    = ipv4_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/dnsr_parser.sv -----
// Byte echo, question-name parser and keep decision for the DNS responder.
`default_nettype none

module dnsr_parser
#(
    parameter int MAX_PACKET = dnsr_pkg::MAX_PACKET_DEF
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           fire,
    input  wire logic [7:0]     in_byte,
    input  wire logic           in_last,
    input  dnsr_pkg::dnsr_cfg_t cfg,
    output dnsr_pkg::dnsr_echo_t echo
);

    localparam int PW       = $clog2(MAX_PACKET + 2);
    localparam int NPW      = dnsr_pkg::NAME_POS_W;
    localparam int NAME_CAP = (dnsr_pkg::MAX_DOMAIN < 31) ? dnsr_pkg::MAX_DOMAIN : 31;
    localparam int KEEP_MAX = MAX_PACKET - dnsr_pkg::ANSWER_BYTES;

    logic [PW-1:0]        pos_reg, pos_next;
    dnsr_pkg::dnsr_phase_t phase_reg, phase_next;
    logic [7:0]           label_rem_reg, label_rem_next;
    logic [NPW-1:0]       name_pos_reg, name_pos_next;
    logic                 match_reg, match_next;
    logic                 first_seen_reg, first_seen_next;

    logic                 add_char;
    logic [7:0]           char_v;
    logic [7:0]           label_dec;
    logic [7:0]           want_char;
    logic [NPW-1:0]       cmp_len;
    logic [7:0]           echo_byte;
    logic                 keep_v;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[8'h41:8'h5A]})
            r = c + 8'h20;
        return r;
    endfunction

    assign cmp_len = (NPW'(cfg.dom_len) > NPW'(NAME_CAP)) ? NPW'(NAME_CAP)
                                                           : NPW'(cfg.dom_len);
    assign want_char = (name_pos_reg < NPW'(dnsr_pkg::NAME_CHARS))
                       ? cfg.chars[name_pos_reg[4:0]] : 8'h00;
    assign label_dec = (label_rem_reg != 8'd0) ? label_rem_reg - 8'd1 : label_rem_reg;

    // next phase and label bookkeeping
    always_comb
    begin
        phase_next      = phase_reg;
        label_rem_next  = label_rem_reg;
        first_seen_next = first_seen_reg;
        case (phase_reg)
            dnsr_pkg::PH_HEADER:
            begin
                if (pos_reg >= PW'(dnsr_pkg::HDR_BYTES - 1))
                    phase_next = dnsr_pkg::PH_LENGTH;
            end
            dnsr_pkg::PH_LENGTH:
            begin
                if (in_byte == 8'd0)
                    phase_next = dnsr_pkg::PH_DONE;
                else
                begin
                    first_seen_next = 1'b1;
                    label_rem_next  = in_byte;
                    phase_next      = dnsr_pkg::PH_LABEL;
                end
            end
            dnsr_pkg::PH_LABEL:
            begin
                label_rem_next = label_dec;
                if (label_dec == 8'd0)
                    phase_next = dnsr_pkg::PH_LENGTH;
            end
            default: ;
        endcase
    end

    // name character feed, echo rewrite and keep decision
    always_comb
    begin
        add_char = 1'b0;
        char_v   = in_byte;
        case (phase_reg)
            dnsr_pkg::PH_LENGTH:
            begin
                if (in_byte != 8'd0 && first_seen_reg)
                begin
                    add_char = 1'b1;
                    char_v   = dnsr_pkg::DOT_CHAR;
                end
            end
            dnsr_pkg::PH_LABEL: add_char = 1'b1;
            default: ;
        endcase

        match_next    = match_reg;
        name_pos_next = name_pos_reg;
        if (add_char)
        begin
            if (name_pos_reg < cmp_len)
            begin
                if (fold_case(char_v) != fold_case(want_char))
                    match_next = 1'b0;
            end
            else
                match_next = 1'b0;
            if (name_pos_reg != {NPW{1'b1}})
                name_pos_next = name_pos_reg + NPW'(1);
        end

        pos_next = (pos_reg <= PW'(MAX_PACKET)) ? pos_reg + PW'(1) : pos_reg;

        echo_byte = in_byte;
        if (pos_reg == PW'(dnsr_pkg::POS_FLAGS_HI) || pos_reg == PW'(dnsr_pkg::POS_FLAGS_LO))
            echo_byte = in_byte | dnsr_pkg::QR_BIT;
        if (pos_reg == PW'(dnsr_pkg::POS_ANCOUNT_LO))
            echo_byte = 8'h01;

        keep_v = (pos_next >= PW'(dnsr_pkg::HDR_BYTES)) && (pos_next <= PW'(KEEP_MAX))
                 && (phase_next != dnsr_pkg::PH_LABEL)
                 && match_next && (name_pos_next == cmp_len);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            phase_reg      <= dnsr_pkg::PH_HEADER;
            label_rem_reg  <= '0;
            name_pos_reg   <= '0;
            match_reg      <= 1'b1;
            first_seen_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (in_last)
            begin
                pos_reg        <= '0;
                phase_reg      <= dnsr_pkg::PH_HEADER;
                label_rem_reg  <= '0;
                name_pos_reg   <= '0;
                match_reg      <= 1'b1;
                first_seen_reg <= 1'b0;
            end
            else
            begin
                pos_reg        <= pos_next;
                phase_reg      <= phase_next;
                label_rem_reg  <= label_rem_next;
                name_pos_reg   <= name_pos_next;
                match_reg      <= match_next;
                first_seen_reg <= first_seen_next;
            end
        end
    end

    assign echo.fire = fire;
    assign echo.last = in_last;
    assign echo.keep = keep_v;
    assign echo.data = echo_byte;

`include "assert_macros.svh"

    `DNSR_ASSERT(a_header_clean,
        phase_reg == dnsr_pkg::PH_HEADER |-> name_pos_reg == '0 && !first_seen_reg)
    `DNSR_ASSERT(a_label_nonzero, phase_reg == dnsr_pkg::PH_LABEL |-> label_rem_reg != 8'd0)
    `DNSR_ASSERT(a_last_clears, fire && in_last |=> pos_reg == '0 && match_reg)

endmodule

`default_nettype wire

// ----- hw/rtl/dnsr_answer.sv -----
// Output register and 16-byte answer sequencer for the DNS responder.
`default_nettype none

module dnsr_answer
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  dnsr_pkg::dnsr_echo_t echo,
    input  wire logic [31:0]     ipv4,
    output logic                 take_ok,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [7:0]           m_tdata,
    output logic                 m_tlast,
    output logic [0:0]           m_tuser
);

    localparam int IW = dnsr_pkg::ANS_IDX_W;
    localparam logic [IW-1:0] IDX_LAST = IW'(dnsr_pkg::ANSWER_BYTES - 1);

    logic          out_valid_reg;
    logic [7:0]    out_data_reg;
    logic          out_last_reg;
    logic          out_keep_reg;
    logic          append_reg;
    logic [IW-1:0] idx_reg;
    logic          keep_hold_reg;
    logic          load_ok;
    logic          ans_load;

    assign load_ok  = !out_valid_reg || m_tready;
    assign take_ok  = load_ok && !append_reg;
    assign ans_load = append_reg && load_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            append_reg    <= 1'b0;
            idx_reg       <= '0;
        end
        else if (echo.fire)
        begin
            out_valid_reg <= 1'b1;
            if (echo.last)
            begin
                append_reg <= 1'b1;
                idx_reg    <= '0;
            end
        end
        else if (ans_load)
        begin
            out_valid_reg <= 1'b1;
            idx_reg       <= idx_reg + IW'(1);
            if (idx_reg == IDX_LAST)
                append_reg <= 1'b0;
        end
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (echo.fire)
        begin
            out_data_reg <= echo.data;
            out_last_reg <= 1'b0;
            out_keep_reg <= 1'b0;
            if (echo.last)
                keep_hold_reg <= echo.keep;
        end
        else if (ans_load)
        begin
            out_data_reg <= dnsr_pkg::answer_byte(idx_reg, ipv4);
            out_last_reg <= (idx_reg == IDX_LAST);
            out_keep_reg <= (idx_reg == IDX_LAST) && keep_hold_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_keep_reg;

`include "assert_macros.svh"

    `DNSR_ASSERT(a_last_starts_answer, echo.fire && echo.last |=> append_reg && idx_reg == '0)
    `DNSR_ASSERT(a_answer_keeps_valid, append_reg |-> out_valid_reg)
    `DNSR_NEVER(a_end_before_answer, out_valid_reg && out_last_reg && append_reg)

endmodule

`default_nettype wire

// ----- hw/rtl/dns_single_name_responder_unit.sv -----
// Top level of the single-name DNS A-record responder.
`default_nettype none

// A DNS query payload enters one byte per transfer on the slave side and each
// byte appears on the master side in the next cycle, rewritten in the header
// (bit 7 set in bytes 2 and 3, byte 7 forced to 1). From byte 12 on the
// question name is parsed and matched, case-insensitively, against the
// configured name. After the transfer marked tlast the unit appends a
// 16-byte A-record answer (C00C, type A, class IN, TTL 60, configured
// address); the final answer byte carries tlast and, in tuser, the keep flag
// (1 send, 0 drop). Rate: one query byte per cycle while the master side
// accepts, set by the single parse stage feeding the output register;
// after each packet the answer sequencer holds s_tready low while it loads
// the 16 answer bytes into the output register. Configuration writes go to
// a flat register index and must only be issued while no packet is in flight.
module dns_single_name_responder_unit
#(
    parameter int MAX_PACKET = dnsr_pkg::MAX_PACKET_DEF
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // query stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [7:0]                         s_tdata,   // [7:0] in_byte
    input  wire logic                               s_tlast,
    // response stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [7:0]                              m_tdata,   // [7:0] out_byte
    output logic                                    m_tlast,
    output logic [0:0]                              m_tuser,   // [0] keep
    // configuration writes
    input  wire logic                               cfg_we,
    input  wire logic [dnsr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [dnsr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    dnsr_pkg::dnsr_cfg_t  cfg;
    dnsr_pkg::dnsr_echo_t echo;
    logic                 take_ok;
    logic                 in_fire;

    // a transfer is taken whenever the output register can absorb the echo
    // byte and no answer is being appended
    assign s_tready = take_ok;
    assign in_fire  = s_tvalid && take_ok;

    dnsr_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // header rewrite, name match and keep decision, all in the accepting cycle
    dnsr_parser #(
        .MAX_PACKET (MAX_PACKET)
    ) u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (in_fire),
        .in_byte (s_tdata),
        .in_last (s_tlast),
        .cfg     (cfg),
        .echo    (echo)
    );

    // output register plus the appended answer bytes
    dnsr_answer u_answer
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .echo     (echo),
        .ipv4     (cfg.ipv4),
        .take_ok  (take_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
